FILE: rtl/pgm_pkg.sv
// types, constants and helper functions for the binary pgm stream parser
package pgm_pkg;

	localparam int DIM_BITS   = 16;
	localparam int COUNT_BITS = 2 * DIM_BITS + 1;
	localparam int ACC_BITS   = DIM_BITS + 4;

	localparam logic [DIM_BITS-1:0] FIELD_MAX  = {DIM_BITS{1'b1}};
	// one bit wider than a field so that 256 still fits with narrow fields
	localparam logic [DIM_BITS:0]   GRAY_LIMIT = (DIM_BITS + 1)'(256);

	localparam logic [7:0] MAGIC_0 = 8'h50;    // 'P'
	localparam logic [7:0] MAGIC_1 = 8'h35;    // '5'

	localparam int DATA_BITS  = 3 * DIM_BITS + 2 + 8 + COUNT_BITS;
	localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		K_HEADER    = 3'd0,
		K_COMPLETE  = 3'd1,
		K_PIXEL     = 3'd2,
		K_BAD_MAGIC = 3'd3,
		K_IGNORED   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		PH_MAGIC0  = 4'd0,
		PH_MAGIC1  = 4'd1,
		PH_SKIP_W  = 4'd2,
		PH_FIELD_W = 4'd3,
		PH_SKIP_H  = 4'd4,
		PH_FIELD_H = 4'd5,
		PH_SKIP_G  = 4'd6,
		PH_FIELD_G = 4'd7,
		PH_DATA    = 4'd8,
		PH_BAD     = 4'd9,
		PH_DONE    = 4'd10
	} phase_t;

	typedef struct packed {
		kind_t                 kind;
		logic [DIM_BITS-1:0]   image_width;
		logic [DIM_BITS-1:0]   image_height;
		logic [DIM_BITS-1:0]   max_gray_value;
		logic [1:0]            pixel_bytes;
		logic [7:0]            pixel_data;
		logic [COUNT_BITS-1:0] data_index;
		logic                  last_byte;
	} result_t;

	// space, tab, line feed, vertical tab, form feed, carriage return
	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

endpackage

FILE: rtl/pgm_binary_stream_parser_unit.sv
// top level of the binary pgm (p5) stream parser
//
// Takes one byte of a binary pgm file per item on the s_ side and gives one result item per
// input item on the m_ side. The parser checks the magic "P5", skips whitespace, reads width,
// height and maximum gray as decimal text (each saturating at 65535, a non-digit freezes the
// value), and takes exactly one whitespace byte after the maximum gray as the end of the header.
// The following width*height*(bytes per pixel) bytes come out as pixel items with their index,
// the final one with tlast set; later bytes are reported as ignored until s_tuser (restart)
// marks the first byte of a new file. Throughput is one item per clock while s_tready is high:
// every byte is handled by a single combinational pass from the parser state into the result
// register, and the product width*height is formed by one 16x16 multiplier registered ahead of
// its use (there is always at least one byte between the end of the height field and the end
// of the header). m_tvalid comes from the result register. A two-entry output buffer (result
// register plus skid register) keeps s_tready high while a single result waits on m_tready, so
// the input only stalls once two results are held.
module pgm_binary_stream_parser_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] byte_value
	input  logic                            s_tuser,   // [0] restart
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] image_width, [31:16] image_height, [47:32] max_gray_value,
	// [49:48] pixel_bytes, [57:50] pixel_data, [90:58] data_index, [95:91] zero
	output logic [pgm_pkg::TDATA_BITS-1:0]  m_tdata,
	output logic [2:0]                      m_tuser,   // [2:0] kind
	output logic                            m_tlast    // last_byte
);

	localparam int DW = pgm_pkg::DIM_BITS;
	localparam int CW = pgm_pkg::COUNT_BITS;
	localparam int AW = pgm_pkg::ACC_BITS;

	// parser state
	pgm_pkg::phase_t phase_q, phase_d;
	logic [DW-1:0]   acc_q, acc_d;
	logic            stop_q, stop_d;
	logic [DW-1:0]   width_q, width_d;
	logic [DW-1:0]   height_q, height_d;
	logic [DW-1:0]   gray_q, gray_d;
	logic [CW-1:0]   total_q, total_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic [2*DW-1:0] area_q;

	// output buffer
	logic             out_v_q, skid_v_q;
	pgm_pkg::result_t out_q, skid_q, res;

	logic acc_in, out_take;

	// state as seen by this byte, restart wipes it first
	pgm_pkg::phase_t ph_c;
	logic [DW-1:0]   acc_c, width_c, height_c;
	logic            stop_c;
	logic [CW-1:0]   total_c, cnt_c;
	logic [7:0]      c;

	logic            ws, dig, hdr_empty, data_last;
	logic [AW-1:0]   acc_x10;
	logic [DW-1:0]   take_acc;
	logic            take_stop;
	logic [CW-1:0]   cnt_inc;

	assign acc_in   = s_tvalid && s_tready;
	assign out_take = m_tvalid && m_tready;
	assign s_tready = !skid_v_q;

	assign c        = s_tdata;
	assign ph_c     = s_tuser ? pgm_pkg::PH_MAGIC0 : phase_q;
	assign acc_c    = s_tuser ? '0 : acc_q;
	assign stop_c   = s_tuser ? 1'b0 : stop_q;
	assign width_c  = s_tuser ? '0 : width_q;
	assign height_c = s_tuser ? '0 : height_q;
	assign total_c  = s_tuser ? '0 : total_q;
	assign cnt_c    = s_tuser ? '0 : cnt_q;

	assign ws  = pgm_pkg::is_ws(c);
	assign dig = pgm_pkg::is_digit(c);

	// one decimal digit step, saturating
	assign acc_x10 = AW'({acc_c, 3'b000}) + AW'({acc_c, 1'b0}) + AW'(c[3:0]);

	always_comb begin
		if (!stop_c && dig) begin
			take_acc  = (acc_x10 > AW'(pgm_pkg::FIELD_MAX)) ? pgm_pkg::FIELD_MAX
			                                                : acc_x10[DW-1:0];
			take_stop = 1'b0;
		end else begin
			take_acc  = acc_c;
			take_stop = 1'b1;
		end
	end

	// empty image when either dimension is zero
	assign hdr_empty = (width_c == '0) || (height_c == '0);
	assign cnt_inc   = cnt_c + CW'(1);
	assign data_last = (cnt_inc >= total_c);

	// next phase
	always_comb begin
		phase_d = ph_c;
		case (ph_c)
			pgm_pkg::PH_MAGIC0: begin
				phase_d = (c == pgm_pkg::MAGIC_0) ? pgm_pkg::PH_MAGIC1 : pgm_pkg::PH_BAD;
			end
			pgm_pkg::PH_MAGIC1: begin
				phase_d = (c == pgm_pkg::MAGIC_1) ? pgm_pkg::PH_SKIP_W : pgm_pkg::PH_BAD;
			end
			pgm_pkg::PH_SKIP_W: if (!ws) phase_d = pgm_pkg::PH_FIELD_W;
			pgm_pkg::PH_SKIP_H: if (!ws) phase_d = pgm_pkg::PH_FIELD_H;
			pgm_pkg::PH_SKIP_G: if (!ws) phase_d = pgm_pkg::PH_FIELD_G;
			pgm_pkg::PH_FIELD_W: if (ws) phase_d = pgm_pkg::PH_SKIP_H;
			pgm_pkg::PH_FIELD_H: if (ws) phase_d = pgm_pkg::PH_SKIP_G;
			pgm_pkg::PH_FIELD_G: begin
				if (ws) phase_d = hdr_empty ? pgm_pkg::PH_DONE : pgm_pkg::PH_DATA;
			end
			pgm_pkg::PH_DATA: if (data_last) phase_d = pgm_pkg::PH_DONE;
			default: phase_d = ph_c;
		endcase
	end

	// datapath and result
	always_comb begin
		acc_d    = acc_c;
		stop_d   = stop_c;
		width_d  = width_c;
		height_d = height_c;
		gray_d   = s_tuser ? '0 : gray_q;
		total_d  = total_c;
		cnt_d    = cnt_c;
		res      = '0;
		res.kind = pgm_pkg::K_HEADER;
		case (ph_c)
			pgm_pkg::PH_MAGIC0: begin
				if (c != pgm_pkg::MAGIC_0) res.kind = pgm_pkg::K_BAD_MAGIC;
			end
			pgm_pkg::PH_MAGIC1: begin
				if (c != pgm_pkg::MAGIC_1) res.kind = pgm_pkg::K_BAD_MAGIC;
			end
			pgm_pkg::PH_SKIP_W, pgm_pkg::PH_SKIP_H, pgm_pkg::PH_SKIP_G: begin
				if (!ws) begin
					acc_d  = take_acc;
					stop_d = take_stop;
				end
			end
			pgm_pkg::PH_FIELD_W, pgm_pkg::PH_FIELD_H: begin
				if (ws) begin
					if (ph_c == pgm_pkg::PH_FIELD_W) width_d = acc_c;
					else height_d = acc_c;
					acc_d  = '0;
					stop_d = 1'b0;
				end else begin
					acc_d  = take_acc;
					stop_d = take_stop;
				end
			end
			pgm_pkg::PH_FIELD_G: begin
				if (ws) begin
					gray_d        = acc_c;
					acc_d         = '0;
					stop_d        = 1'b0;
					// two bytes per pixel doubles the byte count
					total_d       = (acc_c < pgm_pkg::GRAY_LIMIT) ? {1'b0, area_q}
					                                              : {area_q, 1'b0};
					cnt_d         = '0;
					res.kind      = pgm_pkg::K_COMPLETE;
					res.last_byte = hdr_empty;
				end else begin
					acc_d  = take_acc;
					stop_d = take_stop;
				end
			end
			pgm_pkg::PH_DATA: begin
				res.kind       = pgm_pkg::K_PIXEL;
				res.pixel_data = c;
				res.data_index = cnt_c;
				res.last_byte  = data_last;
				cnt_d          = cnt_inc;
			end
			default: res.kind = pgm_pkg::K_IGNORED;
		endcase
		res.image_width    = width_d;
		res.image_height   = height_d;
		res.max_gray_value = gray_d;
		res.pixel_bytes    = (gray_d < pgm_pkg::GRAY_LIMIT) ? 2'd1 : 2'd2;
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pgm_pkg::PH_MAGIC0;
			acc_q    <= '0;
			stop_q   <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			gray_q   <= '0;
			total_q  <= '0;
			cnt_q    <= '0;
		end else if (acc_in) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			stop_q   <= stop_d;
			width_q  <= width_d;
			height_q <= height_d;
			gray_q   <= gray_d;
			total_q  <= total_d;
			cnt_q    <= cnt_d;
		end
	end

	// image area, settles well before the end of the header
	always_ff @(posedge clk) begin
		area_q <= (2*DW)'(width_q) * (2*DW)'(height_q);
	end

	// output register plus skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out_take) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= acc_in;
				end
			end else if (acc_in) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out_take) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (acc_in) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last_byte;
	assign m_tdata  = {{(pgm_pkg::TDATA_BITS - pgm_pkg::DATA_BITS){1'b0}},
	                   out_q.data_index, out_q.pixel_data, out_q.pixel_bytes,
	                   out_q.max_gray_value, out_q.image_height, out_q.image_width};

	// skid entry only ever sits behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry valid without output entry");

	// data phase always has bytes left to pass
	a_data_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == pgm_pkg::PH_DATA) |-> (total_q != '0) && (cnt_q < total_q))
		else $error("data phase with no bytes remaining");

	// empty image goes straight to done after header complete
	a_empty_done: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && res.kind == pgm_pkg::K_COMPLETE && res.last_byte)
		|=> (phase_q == pgm_pkg::PH_DONE))
		else $error("empty image did not end the data phase");

	// pixel index stays inside the image
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_in && res.kind == pgm_pkg::K_PIXEL) |-> (res.data_index < total_c))
		else $error("pixel index beyond image size");

endmodule

FILE: tb/tb_pgm_binary_stream_parser_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the binary pgm stream parser: directed and random pgm byte streams
module tb_pgm_binary_stream_parser_unit;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 800;
	localparam int DRAIN_CYCLES = 8;

	// ascii bytes used by the stimulus and the parser model
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [7:0]                     s_tdata  = '0;    // [7:0] byte_value
	logic                           s_tuser  = 1'b0;  // [0] restart
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	// [15:0] image_width, [31:16] image_height, [47:32] max_gray_value,
	// [49:48] pixel_bytes, [57:50] pixel_data, [90:58] data_index
	logic [pgm_pkg::TDATA_BITS-1:0] m_tdata;
	logic [2:0]                     m_tuser;          // [2:0] kind
	logic                           m_tlast;          // last_byte

	// parser model state
	pgm_pkg::phase_t                mdl_phase;
	int unsigned                    mdl_acc;
	logic                           mdl_stopped;
	logic [pgm_pkg::DIM_BITS-1:0]   mdl_width;
	logic [pgm_pkg::DIM_BITS-1:0]   mdl_height;
	logic [pgm_pkg::DIM_BITS-1:0]   mdl_gray;
	logic [pgm_pkg::COUNT_BITS-1:0] mdl_total;
	logic [pgm_pkg::COUNT_BITS-1:0] mdl_count;

	pgm_pkg::result_t parse_results_due[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned useful_items  = 0;
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;
	int unsigned kind_count[5] = '{default: 0};
	logic [7:0]  blank_set[6]  = '{CH_SPACE, CH_TAB, 8'h0A, CH_VT, CH_FF, CH_CR};

	pgm_binary_stream_parser_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- parser model

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic void clear_parser();
		mdl_phase   = pgm_pkg::PH_MAGIC0;
		mdl_acc     = 0;
		mdl_stopped = 1'b0;
		mdl_width   = '0;
		mdl_height  = '0;
		mdl_gray    = '0;
		mdl_total   = '0;
		mdl_count   = '0;
	endfunction

	// digits build the value with saturation, anything else freezes it
	function automatic void take_char(input logic [7:0] c);
		int unsigned v;
		if (!mdl_stopped && c >= CH_ZERO && c <= CH_NINE) begin
			v = mdl_acc * 10 + (32'(c) - 32'(CH_ZERO));
			mdl_acc = (v > 32'(pgm_pkg::FIELD_MAX)) ? 32'(pgm_pkg::FIELD_MAX) : v;
		end else begin
			mdl_stopped = 1'b1;
		end
	endfunction

	function automatic logic [pgm_pkg::DIM_BITS-1:0] end_field();
		logic [pgm_pkg::DIM_BITS-1:0] v;
		v = mdl_acc[pgm_pkg::DIM_BITS-1:0];
		mdl_acc = 0;
		mdl_stopped = 1'b0;
		return v;
	endfunction

	function automatic pgm_pkg::result_t predict_parse(input logic [7:0] c, input logic rs);
		pgm_pkg::result_t r;
		logic [63:0]      prod;
		r = '0;
		r.kind = pgm_pkg::K_HEADER;
		if (rs) clear_parser();
		case (mdl_phase)
			pgm_pkg::PH_MAGIC0: begin
				if (c == pgm_pkg::MAGIC_0) mdl_phase = pgm_pkg::PH_MAGIC1;
				else begin
					r.kind = pgm_pkg::K_BAD_MAGIC;
					mdl_phase = pgm_pkg::PH_BAD;
				end
			end
			pgm_pkg::PH_MAGIC1: begin
				if (c == pgm_pkg::MAGIC_1) mdl_phase = pgm_pkg::PH_SKIP_W;
				else begin
					r.kind = pgm_pkg::K_BAD_MAGIC;
					mdl_phase = pgm_pkg::PH_BAD;
				end
			end
			pgm_pkg::PH_SKIP_W, pgm_pkg::PH_SKIP_H, pgm_pkg::PH_SKIP_G: begin
				if (!is_blank(c)) begin
					take_char(c);
					mdl_phase = pgm_pkg::phase_t'(mdl_phase + 4'd1);
				end
			end
			pgm_pkg::PH_FIELD_W: begin
				if (is_blank(c)) begin
					mdl_width = end_field();
					mdl_phase = pgm_pkg::PH_SKIP_H;
				end else take_char(c);
			end
			pgm_pkg::PH_FIELD_H: begin
				if (is_blank(c)) begin
					mdl_height = end_field();
					mdl_phase = pgm_pkg::PH_SKIP_G;
				end else take_char(c);
			end
			pgm_pkg::PH_FIELD_G: begin
				if (is_blank(c)) begin
					mdl_gray = end_field();
					prod = 64'(mdl_width) * 64'(mdl_height) *
						((mdl_gray < pgm_pkg::GRAY_LIMIT) ? 64'd1 : 64'd2);
					mdl_total = prod[pgm_pkg::COUNT_BITS-1:0];
					mdl_count = '0;
					r.kind = pgm_pkg::K_COMPLETE;
					if (mdl_total == '0) begin
						r.last_byte = 1'b1;
						mdl_phase = pgm_pkg::PH_DONE;
					end else mdl_phase = pgm_pkg::PH_DATA;
				end else take_char(c);
			end
			pgm_pkg::PH_DATA: begin
				r.kind = pgm_pkg::K_PIXEL;
				r.pixel_data = c;
				r.data_index = mdl_count;
				if ({1'b0, mdl_count} + 1 >= {1'b0, mdl_total}) begin
					r.last_byte = 1'b1;
					mdl_phase = pgm_pkg::PH_DONE;
				end
				mdl_count = mdl_count + 1'b1;
			end
			default: begin
				r.kind = pgm_pkg::K_IGNORED;
			end
		endcase
		r.image_width    = mdl_width;
		r.image_height   = mdl_height;
		r.max_gray_value = mdl_gray;
		r.pixel_bytes    = (mdl_gray < pgm_pkg::GRAY_LIMIT) ? 2'd1 : 2'd2;
		return r;
	endfunction

	// ---------------------------------------------------------------- monitors

	// every accepted byte gives exactly one result item
	always @(posedge clk) begin
		pgm_pkg::result_t want;
		if (arst_n && s_tvalid && s_tready) begin
			want = predict_parse(s_tdata, s_tuser);
			parse_results_due.push_back(want);
			if (want.kind != pgm_pkg::K_IGNORED) useful_items++;
		end
	end

	function automatic void check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		pgm_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			if (parse_results_due.size() == 0) begin
				$error("result item with no prediction waiting");
				error_count++;
			end else begin
				want = parse_results_due.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_tuser));
				check_field("image_width", 64'(want.image_width), 64'(m_tdata[15:0]));
				check_field("image_height", 64'(want.image_height), 64'(m_tdata[31:16]));
				check_field("max_gray_value", 64'(want.max_gray_value),
					64'(m_tdata[47:32]));
				check_field("pixel_bytes", 64'(want.pixel_bytes), 64'(m_tdata[49:48]));
				check_field("pixel_data", 64'(want.pixel_data), 64'(m_tdata[57:50]));
				check_field("data_index", 64'(want.data_index), 64'(m_tdata[90:58]));
				check_field("last_byte", 64'(want.last_byte), 64'(m_tlast));
				kind_count[want.kind]++;
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// ---------------------------------------------------------------- stimulus

	// holds s_tvalid high from one item to the next, drops it only for a gap
	task automatic send_byte(input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= rs;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_text(input string s, input logic rs_first);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], rs_first && i == 0);
	endtask

	function automatic logic [7:0] random_junk();
		logic [7:0] c;
		do c = 8'($urandom_range(255));
		while (is_blank(c) || (c >= CH_ZERO && c <= CH_NINE));
		return c;
	endfunction

	task automatic send_blanks(input int unsigned n);
		repeat (n) send_byte(blank_set[$urandom_range(5)], 1'b0);
	endtask

	// decimal field, sometimes signed, zero-padded, junk-only or junk-terminated;
	// the effective value never exceeds the one given
	task automatic send_field(input int unsigned value);
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 5) begin
			send_byte(random_junk(), 1'b0);
		end else begin
			if (pick < 12) send_byte($urandom_range(1) ? CH_MINUS : CH_PLUS, 1'b0);
			else if (pick < 22) send_text("00", 1'b0);
			send_text($sformatf("%0d", value), 1'b0);
			if ($urandom_range(99) < 12) send_byte(random_junk(), 1'b0);
		end
		send_byte(blank_set[$urandom_range(5)], 1'b0);
	endtask

	task automatic send_random_file();
		int unsigned wd, ht, gray, total, pick;
		pick = $urandom_range(99);
		if (pick < 7) begin
			// line noise with random restarts
			repeat ($urandom_range(1, 6))
				send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
			return;
		end
		wd = $urandom_range(5);
		ht = $urandom_range(4);
		if (pick < 15) begin
			wd = $urandom_range(6, 20);
			ht = $urandom_range(1, 3);
		end
		case ($urandom_range(5))
			0: gray = 255;
			1: gray = 256;
			2: gray = 65535;
			3: gray = $urandom_range(300);
			4: gray = $urandom_range(70000);
			default: gray = 1;
		endcase
		// saturating width only with an empty image so the data stays short
		if ($urandom_range(14) == 0) begin
			wd = $urandom_range(65536, 999999);
			ht = 0;
		end
		if ($urandom_range(19) == 0) begin
			send_byte(8'($urandom_range(255)), 1'b1);
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
			return;
		end
		send_byte(pgm_pkg::MAGIC_0, 1'b1);
		if ($urandom_range(19) == 0) begin
			send_byte(8'($urandom_range(255)), 1'b0);
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
			return;
		end
		send_byte(pgm_pkg::MAGIC_1, 1'b0);
		send_blanks($urandom_range(2));
		send_field(wd);
		send_blanks($urandom_range(2));
		send_field(ht);
		send_blanks($urandom_range(2));
		send_field(gray);
		total = wd * ht * ((gray < 256) ? 1 : 2);
		// cut short now and then: the next file restarts mid-image
		if ($urandom_range(9) == 0) total = $urandom_range(total);
		repeat (total) send_byte(8'($urandom_range(255)), 1'b0);
		if ($urandom_range(5) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_bad_magic();
		send_text("XQ", 1'b0);     // wrong first byte straight after reset, then ignored
		send_text("PQ", 1'b1);     // wrong second byte
		send_byte(pgm_pkg::MAGIC_1, 1'b0);  // still ignored until restart
	endtask

	task automatic test_empty_image();
		send_text("P5 0 7 9\n", 1'b1);  // header complete carries the last mark
	endtask

	task automatic test_wide_pixels();
		logic [7:0] pix[4] = '{CH_SPACE, 8'h00, 8'hFF, 8'h7F};
		send_text("P5", 1'b1);
		send_byte(CH_VT, 1'b0);
		send_text("1", 1'b0);
		send_byte(CH_FF, 1'b0);
		send_text("2 256", 1'b0);
		send_byte(CH_TAB, 1'b0);
		// first pixel is whitespace and must still be data
		foreach (pix[i]) send_byte(pix[i], 1'b0);
		send_byte(pgm_pkg::MAGIC_0, 1'b0);       // trailing byte without restart
	endtask

	task automatic test_saturation_and_signs();
		send_text("P5  99999x1 -3 +", 1'b1);
		send_byte(CH_CR, 1'b0);
	endtask

	task automatic test_random_files(input int unsigned snd_pct, input int unsigned rcv_pct,
		input int unsigned n);
		int unsigned target;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		target = useful_items + n;
		while (useful_items < target) send_random_file();
	endtask

	initial begin
		clear_parser();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 29;
		recv_idle_pct = 55;
		test_bad_magic();
		test_empty_image();
		test_wide_pixels();
		test_saturation_and_signs();
		test_random_files(29, 55, RANDOM_ITEMS / 3);
		test_random_files(55, 29, RANDOM_ITEMS / 3);
		test_random_files(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (parse_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d header, %0d complete, %0d pixel, %0d bad magic, %0d ignored items",
			kind_count[pgm_pkg::K_HEADER], kind_count[pgm_pkg::K_COMPLETE],
			kind_count[pgm_pkg::K_PIXEL], kind_count[pgm_pkg::K_BAD_MAGIC],
			kind_count[pgm_pkg::K_IGNORED]);
		$display("directed magic, empty, two-byte and saturation headers, random files, 3 pacings");
		if (error_count == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
			parse_results_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
